### design/upc_pkg.sv
// Package for the URL percent codec: mode codes, character constants,
// the job record passed from the front end to the back end, and hex helpers.
// Depends on nothing.
package upc_pkg;

   localparam logic [1:0] MODE_ENCODE = 2'd0;
   localparam logic [1:0] MODE_PATH   = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_DECODE = 2'd3;

   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   localparam logic [4:0] HEX_BASE = 5'd16;
   localparam logic [3:0] HEX_TEN  = 4'd10;

   localparam int JOB_BYTES     = 3;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } upc_job_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = b - 8'h41 + {4'h0, HEX_TEN};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = b - 8'h61 + {4'h0, HEX_TEN};
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < HEX_TEN) begin
         return 8'h30 + {4'h0, v};
      end
      return 8'h41 + {4'h0, v - HEX_TEN};
   endfunction

endpackage

### design/upc_req_if.sv
// Request channel of the URL percent codec: one input byte per request.
// Depends on nothing.
interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

### design/upc_rsp_if.sv
// Response channel of the URL percent codec: one output byte per response.
// Depends on nothing.
interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source(output valid, output out_byte, output out_last, input ready);
   modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

### design/url_percent_codec.sv
// Top level of the URL percent codec: front end, job queue and back end.
// Depends on upc_pkg, upc_req_if, upc_rsp_if, upc_front, upc_queue, upc_back.
//
// Each request carries one byte of a string and a flag on its last byte.
// Each response carries one output byte and a flag on the final byte of
// the string. The csr port writes the 2-bit coding mode: 0 encodes, 1 also
// keeps '/', 2 writes a space as '+', 3 decodes. A write also drops any
// partly received escape, so write it only while the block is idle.
// A request that encodes to a percent escape yields three responses; a
// request in decode mode yields zero, one, two or three responses.
// The first response of a request passes through the job queue, the
// current-job register and the response register. The response port
// sends one byte per cycle while the receiver is ready. The front end
// takes a new request every cycle while the job queue has room.
// When the receiver stalls, the response register holds its byte, the
// queue fills and request ready drops. Reset selects mode 0, clears the
// decoder and queue and leaves no response pending.
module url_percent_codec #(
   parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   upc_req_if.sink    req,
   upc_rsp_if.source  rsp
);

   upc_pkg::upc_job_type push_job;
   upc_pkg::upc_job_type pop_job;
   logic push_valid;
   logic queue_full;
   logic queue_empty;
   logic pop;

   upc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   upc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .pop_job    (pop_job)
   );

   upc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (queue_empty),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

### design/upc_front.sv
// Front end of the URL percent codec: holds the mode register and decoder
// state, classifies each input byte and builds a job of up to three bytes.
// Depends on upc_pkg and upc_req_if.
module upc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_write_data,
   upc_req_if.sink              req,
   input  logic                 queue_full,
   output logic                 push_valid,
   output upc_pkg::upc_job_type push_job
);

   logic [1:0] mode_ff, mode_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_bytes_ff [2];
   logic [7:0] held_bytes_in [2];
   logic       accept;
   logic       pass;
   logic       fresh;
   logic [7:0] b;
   logic       last;
   upc_pkg::upc_job_type job;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign last      = req.last_byte;

   assign pass = upc_pkg::is_alnum(b) || b == upc_pkg::CH_DASH || b == upc_pkg::CH_UNDER ||
                 b == upc_pkg::CH_DOT || b == upc_pkg::CH_TILDE ||
                 (mode_ff == upc_pkg::MODE_PATH && b == upc_pkg::CH_SLASH);

   always_comb begin
      job              = '0;
      job.last         = last;
      fresh            = 1'b0;
      held_count_in    = held_count_ff;
      held_bytes_in[0] = held_bytes_ff[0];
      held_bytes_in[1] = held_bytes_ff[1];
      if (mode_ff != upc_pkg::MODE_DECODE) begin
         if (pass) begin
            job.bytes[0] = b;
            job.count    = 2'd1;
         end else if (mode_ff == upc_pkg::MODE_QUERY && b == upc_pkg::CH_SPACE) begin
            job.bytes[0] = upc_pkg::CH_PLUS;
            job.count    = 2'd1;
         end else begin
            job.bytes[0] = upc_pkg::CH_PERCENT;
            job.bytes[1] = upc_pkg::hex_digit(b[7:4]);
            job.bytes[2] = upc_pkg::hex_digit(b[3:0]);
            job.count    = 2'd3;
         end
      end else begin
         unique case (held_count_ff)
            upc_pkg::HELD_NONE: begin
               fresh = 1'b1;
            end
            upc_pkg::HELD_ONE: begin
               if (upc_pkg::is_hex(b) && !last) begin
                  held_count_in    = upc_pkg::HELD_TWO;
                  held_bytes_in[1] = b;
               end else if (upc_pkg::is_hex(b)) begin
                  held_count_in = upc_pkg::HELD_NONE;
                  job.bytes[0]  = held_bytes_ff[0];
                  job.bytes[1]  = b;
                  job.count     = 2'd2;
               end else begin
                  held_count_in = upc_pkg::HELD_NONE;
                  job.bytes[0]  = held_bytes_ff[0];
                  job.count     = 2'd1;
                  fresh         = 1'b1;
               end
            end
            upc_pkg::HELD_TWO: begin
               held_count_in = upc_pkg::HELD_NONE;
               if (upc_pkg::is_hex(b)) begin
                  job.bytes[0] = {upc_pkg::hex_val(held_bytes_ff[1]), upc_pkg::hex_val(b)};
                  job.count    = 2'd1;
               end else begin
                  job.bytes[0] = held_bytes_ff[0];
                  job.bytes[1] = held_bytes_ff[1];
                  job.count    = 2'd2;
                  fresh        = 1'b1;
               end
            end
            default: begin
               held_count_in = upc_pkg::HELD_NONE;
               fresh         = 1'b1;
            end
         endcase
         if (fresh) begin
            if (b == upc_pkg::CH_PERCENT && !last) begin
               held_count_in    = upc_pkg::HELD_ONE;
               held_bytes_in[0] = b;
            end else begin
               job.bytes[job.count] = (b == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : b;
               job.count            = job.count + 2'd1;
            end
         end
      end
   end

   assign mode_in    = csr_write_enable ? csr_write_data : mode_ff;
   assign push_valid = accept && job.count != 2'd0;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= upc_pkg::MODE_ENCODE;
         held_count_ff <= upc_pkg::HELD_NONE;
      end else begin
         mode_ff <= mode_in;
         if (csr_write_enable) begin
            held_count_ff <= upc_pkg::HELD_NONE;
         end else if (accept) begin
            held_count_ff <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_bytes_ff[0] <= held_bytes_in[0];
         held_bytes_ff[1] <= held_bytes_in[1];
      end
   end

endmodule

### design/upc_queue.sv
// Short job queue between the front end and the back end of the codec.
// Depends on upc_pkg.
module upc_queue #(
   parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  upc_pkg::upc_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output upc_pkg::upc_job_type pop_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   upc_pkg::upc_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/upc_back.sv
// Back end of the codec: takes jobs from the queue and sends their bytes
// one per cycle, while the receiver is ready, through a registered response channel.
// Depends on upc_pkg and upc_rsp_if.
module upc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  upc_pkg::upc_job_type pop_job,
   output logic                 pop,
   upc_rsp_if.source            rsp
);

   upc_pkg::upc_job_type cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       advance;
   logic       emit;
   logic       final_byte;

   assign advance    = !rsp_valid_ff || rsp.ready;
   assign emit       = advance && cur_valid_ff;
   assign final_byte = idx_ff == cur_ff.count - 2'd1;
   assign pop        = !empty && (!cur_valid_ff || (emit && final_byte));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = advance ? cur_valid_ff : rsp_valid_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (emit) begin
         cur_valid_in = !final_byte;
         idx_in       = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_job;
      end
      if (emit) begin
         rsp_byte_ff <= cur_ff.bytes[idx_ff];
         rsp_last_ff <= cur_ff.last && final_byte;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.out_last = rsp_last_ff;

endmodule
